### rtl/ttsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttsl_pkg
// Shared types, glyph table and segment placement functions for the
// text to segment LCD frame builder.
// ----------------------------------------------------------------------------
package ttsl_pkg;

  localparam int CODE_W      = 7;
  localparam int WORD_W      = 27;
  localparam int LINE_COUNT  = 4;
  localparam int POS_W       = 4;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGIT_COUNT_DEFAULT = 10;

  localparam logic [CODE_W-1:0] CHAR_PERIOD = 7'h2E;
  localparam logic [CODE_W-1:0] CHAR_COMMA  = 7'h2C;
  localparam logic [CODE_W-1:0] CODE_FIRST  = 7'h20;
  localparam logic [CODE_W-1:0] CODE_LAST   = 7'h5F;

  typedef logic [7:0]        segs_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [LINE_COUNT-1:0] frame_t;

  localparam segs_t DP_BIT = 8'h80;

  localparam int SEG_BASE [MAX_DIGITS] = '{1, 4, 6, 9, 11, 14, 16, 19, 21, 24};

  localparam segs_t GLYPHS [64] = '{
    8'h00, 8'h82, 8'h22, 8'h7e, 8'h2d, 8'h72, 8'h3c, 8'h02,
    8'h31, 8'h0e, 8'h63, 8'h46, 8'h0c, 8'h40, 8'h80, 8'h36,
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h09, 8'h0d, 8'h60, 8'h48, 8'h42, 8'h83,
    8'h7b, 8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h3d,
    8'h76, 8'h04, 8'h0e, 8'h75, 8'h38, 8'h35, 8'h54, 8'h5c,
    8'h73, 8'h67, 8'h50, 8'h4d, 8'h78, 8'h3e, 8'h1c, 8'h3a,
    8'h64, 8'h6e, 8'h59, 8'h39, 8'h1b, 8'h0f, 8'h23, 8'h08
  };

  // Codes outside the table show blank.
  function automatic segs_t glyph_lookup(input logic [CODE_W-1:0] code);
    segs_t g;
    g = '0;
    if (code >= CODE_FIRST && code <= CODE_LAST) begin
      g = GLYPHS[6'(code - CODE_FIRST)];
    end
    return g;
  endfunction

  // OR one digit's segments into the frame; odd and even positions differ.
  function automatic frame_t place_digit(input frame_t f, input logic [POS_W-1:0] pos,
                                         input segs_t s);
    frame_t r;
    int     b;
    r = f;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      b = SEG_BASE[p];
      if (pos == POS_W'(p)) begin
        if ((p % 2) == 1) begin
          r[3][b-1] = r[3][b-1] | s[0];
          r[3][b]   = r[3][b]   | s[5];
          r[3][b+1] = r[3][b+1] | s[1];
          r[2][b]   = r[2][b]   | s[4];
          r[2][b+1] = r[2][b+1] | s[6];
          r[1][b]   = r[1][b]   | s[2];
          r[1][b-1] = r[1][b-1] | s[3];
          r[1][b+1] = r[1][b+1] | s[7];
        end else begin
          r[3][b]   = r[3][b]   | s[5];
          r[3][b+1] = r[3][b+1] | s[0];
          r[2][b+2] = r[2][b+2] | s[1];
          r[2][b]   = r[2][b]   | s[4];
          r[2][b+1] = r[2][b+1] | s[6];
          r[1][b+1] = r[1][b+1] | s[2];
          r[1][b]   = r[1][b]   | s[3];
          r[0][b+2] = r[0][b+2] | s[7];
        end
      end
    end
    return r;
  endfunction

  // The comma mark lives on line 0, one above the position's base bit.
  function automatic frame_t place_comma(input frame_t f, input logic [POS_W-1:0] pos);
    frame_t r;
    r = f;
    for (int p = 0; p < MAX_DIGITS; p++) begin
      if (pos == POS_W'(p)) begin
        r[0][SEG_BASE[p]+1] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/ttsl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttsl_in_if / ttsl_out_if
// Valid/ready channels for characters in and segment frames out.
// ----------------------------------------------------------------------------
interface ttsl_in_if;
  logic                          valid;
  logic                          ready;
  logic [ttsl_pkg::CODE_W-1:0]   char_code;
  logic                          last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ttsl_out_if;
  logic                 valid;
  logic                 ready;
  ttsl_pkg::word_t      com0_out;
  ttsl_pkg::word_t      com1_out;
  ttsl_pkg::word_t      com2_out;
  ttsl_pkg::word_t      com3_out;

  modport source (output valid, output com0_out, output com1_out, output com2_out,
                  output com3_out, input ready);
  modport sink   (input valid, input com0_out, input com1_out, input com2_out,
                  input com3_out, output ready);
endinterface
`default_nettype wire

### rtl/text_to_segment_lcd_frame_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_segment_lcd_frame_top
// Builds four 27-bit LCD common-line words from a string of characters.
// ----------------------------------------------------------------------------
// Usage:
// Characters arrive on in_bus, one beat per character, with last_char set on
// the final character of a string. Each character is looked up in a
// seven-segment glyph table and held until the next beat shows whether a
// '.' or ',' follows; the held digit is then placed into the frame. Up to
// DIGIT_COUNT digits are drawn and later characters are ignored.
// Only a last character produces an out_bus beat carrying the four line
// words; other beats produce nothing.
// The frame appears on out_bus in the cycle after the last character
// is accepted. Throughput: one character per cycle while in_bus.ready is high;
// the per-character work is a table lookup and a ten-way bit placement ahead
// of the state and output registers.
// Stalls: the result sits in a single output register. in_bus.ready stays
// high while that register is empty or being drained, so a stalled receiver
// holds off new characters only while a finished frame is still waiting.
// Reset: rst_n (synchronous) empties the output register and arms the
// builder to start a new string with a cleared frame.
// ----------------------------------------------------------------------------
module text_to_segment_lcd_frame_top #(
  parameter int DIGIT_COUNT = ttsl_pkg::DIGIT_COUNT_DEFAULT
) (
  input  wire           clk,
  input  wire           rst_n,
  ttsl_in_if.sink       in_bus,
  ttsl_out_if.source    out_bus
);

  // Builder state.
  ttsl_pkg::segs_t                held_r, held_nxt;
  logic [ttsl_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic                           start_r, start_nxt;
  ttsl_pkg::frame_t               words_r, words_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  ttsl_pkg::frame_t               out_words_r, out_words_nxt;

  // Values after this character, before the final placement.
  ttsl_pkg::segs_t                glyph;
  ttsl_pkg::segs_t                held_mid;
  logic [ttsl_pkg::POS_W-1:0]     pos_mid;
  ttsl_pkg::frame_t               words_mid;
  ttsl_pkg::frame_t               frame_fin;
  logic                           in_ready;
  logic                           accept;

  // A new beat is taken whenever the output register is free or emptying.
  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign accept       = in_bus.valid && in_ready;

  always_comb begin
    glyph     = ttsl_pkg::glyph_lookup(in_bus.char_code);
    held_mid  = held_r;
    pos_mid   = pos_r;
    words_mid = words_r;

    if (start_r) begin
      // The first character is always a digit, even a separator.
      words_mid = '0;
      held_mid  = glyph;
      pos_mid   = '0;
    end else if (pos_r < ttsl_pkg::POS_W'(DIGIT_COUNT)) begin
      if (in_bus.char_code == ttsl_pkg::CHAR_PERIOD ||
          in_bus.char_code == ttsl_pkg::CHAR_COMMA) begin
        held_mid = held_r | ttsl_pkg::DP_BIT;
        if (in_bus.char_code == ttsl_pkg::CHAR_COMMA) begin
          words_mid = ttsl_pkg::place_comma(words_r, pos_r);
        end
      end else begin
        words_mid = ttsl_pkg::place_digit(words_r, pos_r, held_r);
        pos_mid   = pos_r + 1'b1;
        held_mid  = glyph;
      end
    end

    // On the last character the held digit is drawn if there is room.
    frame_fin = words_mid;
    if (pos_mid < ttsl_pkg::POS_W'(DIGIT_COUNT)) begin
      frame_fin = ttsl_pkg::place_digit(words_mid, pos_mid, held_mid);
    end
  end

  always_comb begin
    held_nxt      = held_r;
    pos_nxt       = pos_r;
    start_nxt     = start_r;
    words_nxt     = words_r;
    out_words_nxt = out_words_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;

    if (accept) begin
      held_nxt  = held_mid;
      pos_nxt   = pos_mid;
      words_nxt = words_mid;
      start_nxt = 1'b0;
      if (in_bus.last_char) begin
        words_nxt     = frame_fin;
        out_words_nxt = frame_fin;
        out_valid_nxt = 1'b1;
        start_nxt     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      pos_r       <= '0;
      start_r     <= 1'b1;
      words_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      pos_r       <= pos_nxt;
      start_r     <= start_nxt;
      words_r     <= words_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    out_words_r <= out_words_nxt;
  end

  assign out_bus.valid    = out_valid_r;
  assign out_bus.com0_out = out_words_r[0];
  assign out_bus.com1_out = out_words_r[1];
  assign out_bus.com2_out = out_words_r[2];
  assign out_bus.com3_out = out_words_r[3];

endmodule
`default_nettype wire

### rtl/ttsl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttsl_checker
// Port-level assertions for the LCD frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module ttsl_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   in_last,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [ttsl_pkg::WORD_W-1:0] com0,
  input wire [ttsl_pkg::WORD_W-1:0] com1,
  input wire [ttsl_pkg::WORD_W-1:0] com2,
  input wire [ttsl_pkg::WORD_W-1:0] com3
);

  // Reset leaves no frame pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("frame pending after reset");

  // An empty output register never blocks characters.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Only a last character yields a frame.
  a_no_frame_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last) |=> !out_valid)
    else $error("frame without last character");

  a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> out_valid)
    else $error("last character gave no frame");

  // A stalled frame holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(com0) && $stable(com1) &&
                                   $stable(com2) && $stable(com3)))
    else $error("stalled frame changed");

endmodule

bind text_to_segment_lcd_frame_top ttsl_checker u_ttsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .in_last   (in_bus.last_char),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .com0      (out_bus.com0_out),
  .com1      (out_bus.com1_out),
  .com2      (out_bus.com2_out),
  .com3      (out_bus.com3_out)
);
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the text to segment LCD frame builder against an independent
// predictor. Strings of characters are sent one beat at a time. Each frame
// that comes back is compared line by line with the frame that the
// predictor built from the same characters. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DIGITS        = 10;
  localparam int CHAR_TARGET   = 1350;
  localparam int CALM_TAIL     = 120;      // last beats are sent with no idling
  localparam int SETTLE_CYCLES = 8;        // the frame comes out in the cycle after the last beat
  localparam int CYCLE_LIMIT   = 200000;

  // Base bit of each digit position inside the 27-bit line words.
  localparam int POS_BASE [10] = '{1, 4, 6, 9, 11, 14, 16, 19, 21, 24};

  // Seven-segment patterns for ASCII 0x20 up to 0x5F.
  // Bit 0 top, 1 upper right, 2 lower right, 3 bottom, 4 lower left,
  // 5 upper left, 6 middle, 7 decimal point.
  localparam logic [7:0] GLYPH_ROM [64] = '{
    8'h00, 8'h82, 8'h22, 8'h7e, 8'h2d, 8'h72, 8'h3c, 8'h02,
    8'h31, 8'h0e, 8'h63, 8'h46, 8'h0c, 8'h40, 8'h80, 8'h36,
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h09, 8'h0d, 8'h60, 8'h48, 8'h42, 8'h83,
    8'h7b, 8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h3d,
    8'h76, 8'h04, 8'h0e, 8'h75, 8'h38, 8'h35, 8'h54, 8'h5c,
    8'h73, 8'h67, 8'h50, 8'h4d, 8'h78, 8'h3e, 8'h1c, 8'h3a,
    8'h64, 8'h6e, 8'h59, 8'h39, 8'h1b, 8'h0f, 8'h23, 8'h08
  };

  // One character beat, plus a flag that makes the sender wait until every
  // frame still owed has come back before it offers this beat.
  typedef struct {
    logic [ttsl_pkg::CODE_W-1:0] code;
    logic                        last;
    bit                          drain_first;
  } char_beat_t;

  logic clk;
  logic rst_n;

  ttsl_in_if  in_bus ();
  ttsl_out_if out_bus ();

  text_to_segment_lcd_frame_top #(.DIGIT_COUNT(DIGITS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Characters still to be sent, and frames the block still owes us.
  char_beat_t        chars_pending [$];
  ttsl_pkg::frame_t  frames_due [$];

  // Predictor state: the digit waiting for a possible separator, how many
  // digits have been drawn, whether the next beat opens a new string, and
  // the frame under construction.
  logic [7:0]       held_glyph;
  int               drawn_digits;
  bit               fresh_string;
  ttsl_pkg::frame_t lcd_lines;

  int  mismatches;
  int  cycle_count;
  int  send_gap;
  int  stall_left;
  bit  tail_calm;
  char_beat_t next_beat;

  // The clock runs from time zero; the first rising edge is at 6 ns.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Every input of the block is known from the first instant of the run.
  initial begin
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.char_code  = '0;
    in_bus.last_char  = 1'b0;
    out_bus.ready     = 1'b1;
    held_glyph        = '0;
    drawn_digits      = 0;
    fresh_string      = 1'b1;
    lcd_lines         = '0;
    mismatches        = 0;
    cycle_count       = 0;
    send_gap          = 0;
    stall_left        = 0;
    tail_calm         = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Codes outside the printable part of the table show no segments at all.
  function automatic logic [7:0] glyph_of(input logic [ttsl_pkg::CODE_W-1:0] code);
    if (code >= 7'h20 && code <= 7'h5F) begin
      return GLYPH_ROM[code - 7'h20];
    end
    return 8'h00;
  endfunction

  // OR one digit into the frame. Odd and even positions wire their segments
  // to different bits around the position's base bit; only even positions
  // put their decimal point on line 0.
  function automatic void draw_digit(input int pos, input logic [7:0] s);
    int b;
    if (pos >= DIGITS) begin
      return;
    end
    b = POS_BASE[pos];
    if (pos % 2 == 1) begin
      lcd_lines[3][b-1] |= s[0];
      lcd_lines[3][b]   |= s[5];
      lcd_lines[3][b+1] |= s[1];
      lcd_lines[2][b]   |= s[4];
      lcd_lines[2][b+1] |= s[6];
      lcd_lines[1][b]   |= s[2];
      lcd_lines[1][b-1] |= s[3];
      lcd_lines[1][b+1] |= s[7];
    end else begin
      lcd_lines[3][b]   |= s[5];
      lcd_lines[3][b+1] |= s[0];
      lcd_lines[2][b+2] |= s[1];
      lcd_lines[2][b]   |= s[4];
      lcd_lines[2][b+1] |= s[6];
      lcd_lines[1][b+1] |= s[2];
      lcd_lines[1][b]   |= s[3];
      lcd_lines[0][b+2] |= s[7];
    end
  endfunction

  // Advance the predictor by one accepted character. A finished string
  // queues the frame that the block must return.
  function automatic void encode_char(input logic [ttsl_pkg::CODE_W-1:0] code,
                                      input logic last);
    logic [7:0] g;
    g = glyph_of(code);
    if (fresh_string) begin
      // The first character is always a digit, even a separator.
      lcd_lines    = '0;
      held_glyph   = g;
      drawn_digits = 0;
      fresh_string = 1'b0;
    end else if (drawn_digits < DIGITS) begin
      if (code == ttsl_pkg::CHAR_PERIOD || code == ttsl_pkg::CHAR_COMMA) begin
        held_glyph[7] = 1'b1;
        if (code == ttsl_pkg::CHAR_COMMA) begin
          lcd_lines[0][POS_BASE[drawn_digits] + 1] = 1'b1;
        end
      end else begin
        draw_digit(drawn_digits, held_glyph);
        drawn_digits = drawn_digits + 1;
        held_glyph   = g;
      end
    end
    // Once all positions are full, further characters change nothing and
    // a digit still held is dropped.
    if (last) begin
      if (drawn_digits < DIGITS) begin
        draw_digit(drawn_digits, held_glyph);
      end
      frames_due.push_back(lcd_lines);
      fresh_string = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void add_char(input logic [ttsl_pkg::CODE_W-1:0] code, input logic last,
                                   input bit drain_first);
    char_beat_t c;
    c.code        = code;
    c.last        = last;
    c.drain_first = drain_first;
    chars_pending.push_back(c);
  endfunction

  function automatic void add_text(input string s, input bit drain_first);
    for (int i = 0; i < s.len(); i++) begin
      add_char(ttsl_pkg::CODE_W'(s[i]), i == s.len() - 1, drain_first && i == 0);
    end
  endfunction

  // A plausible display string: digits and table characters, each character
  // followed now and then by a decimal point or a comma.
  function automatic void add_number_string(input int len, input bit drain_first);
    logic [ttsl_pkg::CODE_W-1:0] c;
    int                          n;
    n = 0;
    while (n < len) begin
      if ($urandom_range(0, 2) == 0) begin
        c = ttsl_pkg::CODE_W'($urandom_range(32, 95));
      end else begin
        c = ttsl_pkg::CODE_W'($urandom_range(48, 57));
      end
      add_char(c, n == len - 1, drain_first && n == 0);
      n = n + 1;
      if (n < len && $urandom_range(0, 3) == 0) begin
        add_char($urandom_range(0, 1) ? ttsl_pkg::CHAR_COMMA : ttsl_pkg::CHAR_PERIOD,
                 n == len - 1, 1'b0);
        n = n + 1;
      end
    end
  endfunction

  // Noise: any 7-bit code, in or out of the table.
  function automatic void add_noise_string(input int len);
    for (int i = 0; i < len; i++) begin
      add_char(ttsl_pkg::CODE_W'($urandom_range(0, 127)), i == len - 1, 1'b0);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int len;

    // Directed part. A lone '.' must show its own table pattern, since the
    // first character is never treated as a separator.
    add_text(".", 1'b0);
    // A leading comma is a digit too; the '5' after it is the second digit.
    add_text(",5", 1'b0);
    // The extreme codes lie outside the table and show blank; the comma that
    // follows still lights the decimal point and the comma mark.
    add_char(7'h00, 1'b0, 1'b0);
    add_char(7'h7F, 1'b0, 1'b0);
    add_char(ttsl_pkg::CHAR_COMMA, 1'b1, 1'b0);
    // The table's first and last entries.
    add_text(" _", 1'b0);
    // Two periods in a row: the first is a digit, the second its point.
    add_text("..", 1'b0);
    // All ten positions filled, the first two with a point and a comma; the eleventh digit
    // and the comma after it must be ignored. The sender first waits for
    // every owed frame so this string starts on an empty pipeline.
    add_text("8.8,888888888,", 1'b1);

    // Random part: mostly well-formed numbers, some long enough to overflow
    // the display, and some noise strings.
    while (chars_pending.size() < CHAR_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        add_noise_string($urandom_range(1, 6));
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          len = $urandom_range(10, 16);
        end else begin
          len = $urandom_range(1, 11);
        end
        // Every few hundred beats the sender holds off until the block has
        // returned everything it owes.
        add_number_string(len, (chars_pending.size() % 300) < 8);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to be accepted, then for the last frame.
    while (chars_pending.size() != 0 || in_bus.valid) begin
      @(posedge clk);
    end
    while (frames_due.size() != 0) begin
      @(posedge clk);
    end
    // The settling wait after that catches any frame that the block should not send.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver. A beat that was offered stays on the bus until it is taken.
  // Between beats the sender may idle for a burst of cycles, except near the
  // end of the run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        encode_char(in_bus.char_code, in_bus.last_char);
      end
      tail_calm <= (chars_pending.size() < CALM_TAIL);
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (chars_pending.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (chars_pending[0].drain_first && frames_due.size() != 0) begin
          in_bus.valid <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 13) - 1;
          in_bus.valid <= 1'b0;
        end else begin
          next_beat = chars_pending.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.char_code <= next_beat.code;
          in_bus.last_char <= next_beat.last;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every frame taken from the block is checked against the oldest
  // predicted frame; the receiver stalls in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    ttsl_pkg::frame_t got;
    ttsl_pkg::frame_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b1;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got[0] = out_bus.com0_out;
        got[1] = out_bus.com1_out;
        got[2] = out_bus.com2_out;
        got[3] = out_bus.com3_out;
        if (frames_due.size() == 0) begin
          $error("frame with none expected: com0_out %h com1_out %h com2_out %h com3_out %h",
                 got[0], got[1], got[2], got[3]);
          mismatches = mismatches + 1;
        end else begin
          want = frames_due.pop_front();
          for (int k = 0; k < ttsl_pkg::LINE_COUNT; k++) begin
            if (got[k] !== want[k]) begin
              $error("com%0d_out: expected %h, actual %h", k, want[k], got[k]);
              mismatches = mismatches + 1;
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!tail_calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // A run that hangs fails rather than running forever.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
